### src/nco_pkg.sv
// Shared types, constants and the sine table generator for the quadrature NCO.
// Used by every module of the block; depends on nothing.
package nco_pkg;

  localparam int LUT_ADDR_BITS_DEF = 10;
  localparam int SAMPLE_BITS_DEF   = 16;
  localparam int MAX_BURST_DEF     = 64;

  localparam int COUNT_W     = 7;
  localparam int PHASE_W     = 32;
  localparam int OUT_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 32;
  localparam int CMD_DEPTH   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 1'd1;

  localparam logic [PHASE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [63:0]        HALF_PI_Q30  = 64'd1686629713;

  typedef struct packed {
    logic                  we;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    logic               refuse;
    logic [COUNT_W-1:0] count;
  } cmd_t;

  // Quarter-wave sine entry k, Taylor series in Q2.30, scaled to 2^(sample_bits-1)-1.
  function automatic logic [31:0] sine_entry(int unsigned k, int unsigned addr_bits,
                                             int unsigned sample_bits);
    logic        [63:0] x;
    logic        [63:0] term;
    logic        [63:0] amp;
    logic        [63:0] v;
    logic signed [63:0] sum;
    x    = (64'(k) * HALF_PI_Q30) >> addr_bits;
    term = x;
    sum  = signed'(x);
    amp  = (64'd1 << (sample_bits - 1)) - 64'd1;
    for (int n = 1; n <= 7; n++) begin
      term = (term * x) >> 30;
      term = (term * x) >> 30;
      case (n)
        1:       term = term / 64'd6;
        2:       term = term / 64'd20;
        3:       term = term / 64'd42;
        4:       term = term / 64'd72;
        5:       term = term / 64'd110;
        6:       term = term / 64'd156;
        default: term = term / 64'd210;
      endcase
      if ((n % 2) == 1) sum = sum - signed'(term);
      else              sum = sum + signed'(term);
    end
    if (sum < 0) sum = 64'sd0;
    v = (unsigned'(sum) * amp + (64'd1 << 29)) >> 30;
    if (v > amp) v = amp;
    return v[31:0];
  endfunction

endpackage

### src/complex_nco_iq_generator.sv
// Top level of the quadrature NCO: request front end, command queue and sample back end.
// Depends on nco_pkg, nco_front, nco_cmd_fifo and nco_back.
//
// Usage: software sets phase_step (register 1, signed turns/2^32 per sample) and
// enable (register 0) through the cfg_we/cfg_index/cfg_data port while the block is idle.
// Each request on the s_axis channel carries a sample count; the block answers on the
// m_axis channel with that many cosine/sine pairs (count clamped to MAX_BURST), tlast
// on the final one. A zero count gives nothing. While disabled, a request gives one
// item with zero samples, tlast and tuser set, and the phase holds.
// A request passes the command queue, command register, lookup stage and output register.
// Throughput: one sample per cycle while m_axis_tready stays high; bursts follow each
// other without gaps when the next request is already queued.
// A two-entry command queue lets requests be taken while a burst is still playing.
// Reset clears phase, enable, phase step and all queued work.
// When the receiver drops m_axis_tready the output and lookup stages hold, the
// sequencer stops, and once the queue fills s_axis_tready drops.
module complex_nco_iq_generator #(
  parameter int LUT_ADDR_BITS = nco_pkg::LUT_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS   = nco_pkg::SAMPLE_BITS_DEF,
  parameter int MAX_BURST     = nco_pkg::MAX_BURST_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [nco_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nco_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [7:0]                        s_axis_tdata,  // [6:0] sample_count
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [31:0]                       m_axis_tdata,  // [15:0] i_sample, [31:16] q_sample
  output logic                              m_axis_tlast,
  output logic                              m_axis_tuser   // [0] not_running
);

  nco_pkg::cfg_wr_t cfg;
  nco_pkg::cmd_t    push_cmd;
  nco_pkg::cmd_t    head_cmd;
  logic             push;
  logic             fifo_full;
  logic             head_valid;
  logic             pop;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  nco_front #(
    .MAX_BURST (MAX_BURST)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .req_valid (s_axis_tvalid),
    .req_ready (s_axis_tready),
    .req_count (s_axis_tdata[nco_pkg::COUNT_W-1:0]),
    .push      (push),
    .push_cmd  (push_cmd),
    .fifo_full (fifo_full)
  );

  nco_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  nco_back #(
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (m_axis_tdata),
    .out_last   (m_axis_tlast),
    .out_flag   (m_axis_tuser)
  );

endmodule

### src/nco_cmd_fifo.sv
// Short command queue between the request front end and the sample sequencer.
// Depends on nco_pkg for the command type and queue depth.
module nco_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  nco_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output nco_pkg::cmd_t head_cmd
);

  localparam int PTR_W = (nco_pkg::CMD_DEPTH > 1) ? $clog2(nco_pkg::CMD_DEPTH) : 1;
  localparam int CNT_W = $clog2(nco_pkg::CMD_DEPTH + 1);

  nco_pkg::cmd_t    entries [nco_pkg::CMD_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;
  logic             do_push;
  logic             do_pop;

  assign full       = (fill == CNT_W'(nco_pkg::CMD_DEPTH));
  assign head_valid = (fill != '0);
  assign head_cmd   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(nco_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(nco_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/nco_front.sv
// Request front end: holds the enable register, classifies each burst request
// and queues a command. Depends on nco_pkg.
module nco_front #(
  parameter int MAX_BURST = nco_pkg::MAX_BURST_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  nco_pkg::cfg_wr_t             cfg,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  logic [nco_pkg::COUNT_W-1:0]  req_count,
  output logic                         push,
  output nco_pkg::cmd_t                push_cmd,
  input  logic                         fifo_full
);

  localparam logic [nco_pkg::COUNT_W-1:0] MAX_CNT = nco_pkg::COUNT_W'(MAX_BURST);

  logic enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      enable <= 1'b0;
    end else if (cfg.we && cfg.index == nco_pkg::REG_ENABLE) begin
      enable <= cfg.data[0];
    end
  end

  assign req_ready = !fifo_full;

  // drop zero-length requests while running
  assign push = req_valid && req_ready && (!enable || req_count != '0);

  always_comb begin
    push_cmd.refuse = !enable;
    if (!enable) begin
      push_cmd.count = nco_pkg::COUNT_W'(1);
    end else if (req_count > MAX_CNT) begin
      push_cmd.count = MAX_CNT;
    end else begin
      push_cmd.count = req_count;
    end
  end

endmodule

### src/nco_lut.sv
// Quarter-wave sine lookup with registered read, giving cosine and sine in Q1.15.
// Depends on nco_pkg for the table generator.
module nco_lut #(
  parameter int LUT_ADDR_BITS = nco_pkg::LUT_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS   = nco_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic        [nco_pkg::PHASE_W-1:0] phase,
  output logic signed [nco_pkg::OUT_W-1:0]   i_sample,
  output logic signed [nco_pkg::OUT_W-1:0]   q_sample
);

  localparam int N     = 1 << LUT_ADDR_BITS;
  localparam int IDX_W = LUT_ADDR_BITS + 1;
  localparam int MAG_W = SAMPLE_BITS - 1;
  localparam int SH_R  = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int SH_L  = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int OW    = nco_pkg::OUT_W;

  logic [MAG_W-1:0]            rom [N+1];
  logic [nco_pkg::PHASE_W-1:0] cos_phase;
  logic [IDX_W-1:0]            i_idx;
  logic [IDX_W-1:0]            q_idx;
  logic [MAG_W-1:0]            i_mag;
  logic [MAG_W-1:0]            q_mag;
  logic                        i_neg;
  logic                        q_neg;
  logic [OW-1:0]               i_abs;
  logic [OW-1:0]               q_abs;

  for (genvar k = 0; k <= N; k++) begin : g_rom
    assign rom[k] = MAG_W'(nco_pkg::sine_entry(k, LUT_ADDR_BITS, SAMPLE_BITS));
  end

  function automatic logic [IDX_W-1:0] tab_index(logic [nco_pkg::PHASE_W-1:0] ph);
    logic [IDX_W-1:0] addr;
    addr = {1'b0, ph[29 -: LUT_ADDR_BITS]};
    return ph[30] ? IDX_W'(N) - addr : addr;
  endfunction

  assign cos_phase = phase + nco_pkg::QUARTER_TURN;
  assign i_idx     = tab_index(cos_phase);
  assign q_idx     = tab_index(phase);

  always_ff @(posedge clk) begin
    if (en) begin
      i_mag <= rom[i_idx];
      q_mag <= rom[q_idx];
      i_neg <= cos_phase[31];
      q_neg <= phase[31];
    end
  end

  assign i_abs    = OW'(i_mag >> SH_R) << SH_L;
  assign q_abs    = OW'(q_mag >> SH_R) << SH_L;
  assign i_sample = i_neg ? -i_abs : i_abs;
  assign q_sample = q_neg ? -q_abs : q_abs;

endmodule

### src/nco_back.sv
// Sample sequencer: phase accumulator, burst counter, table lookup stage and
// output register. Depends on nco_pkg and nco_lut.
module nco_back #(
  parameter int LUT_ADDR_BITS = nco_pkg::LUT_ADDR_BITS_DEF,
  parameter int SAMPLE_BITS   = nco_pkg::SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  nco_pkg::cfg_wr_t                 cfg,
  input  logic                             head_valid,
  input  nco_pkg::cmd_t                    head_cmd,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2*nco_pkg::OUT_W-1:0]      out_data,
  output logic                             out_last,
  output logic                             out_flag
);

  logic [nco_pkg::PHASE_W-1:0] phase_step;
  logic [nco_pkg::PHASE_W-1:0] phase_acc;
  logic                        cmd_valid;
  logic                        cmd_refuse;
  logic [nco_pkg::COUNT_W-1:0] burst_left;
  logic                        s1_valid;
  logic                        s1_last;
  logic                        s1_refuse;
  logic                        s2_load;
  logic                        s1_ready;
  logic                        issue;
  logic                        issue_last;
  logic signed [nco_pkg::OUT_W-1:0] lut_i;
  logic signed [nco_pkg::OUT_W-1:0] lut_q;

  assign s2_load    = s1_valid && (!out_valid || out_ready);
  assign s1_ready   = !s1_valid || s2_load;
  assign issue      = cmd_valid && s1_ready;
  assign issue_last = (burst_left == nco_pkg::COUNT_W'(1));
  assign pop        = head_valid && (!cmd_valid || (issue && issue_last));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= '0;
    end else if (cfg.we && cfg.index == nco_pkg::REG_PHASE_STEP) begin
      phase_step <= cfg.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc  <= '0;
      cmd_valid  <= 1'b0;
      cmd_refuse <= 1'b0;
      burst_left <= '0;
    end else begin
      if (issue && !cmd_refuse) begin
        phase_acc <= phase_acc + phase_step;
      end
      if (pop) begin
        cmd_valid  <= 1'b1;
        cmd_refuse <= head_cmd.refuse;
        burst_left <= head_cmd.count;
      end else if (issue) begin
        burst_left <= burst_left - 1'b1;
        if (issue_last) begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  nco_lut #(
    .LUT_ADDR_BITS (LUT_ADDR_BITS),
    .SAMPLE_BITS   (SAMPLE_BITS)
  ) u_lut (
    .clk      (clk),
    .en       (issue),
    .phase    (phase_acc),
    .i_sample (lut_i),
    .q_sample (lut_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_last   <= issue_last;
      s1_refuse <= cmd_refuse;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      out_data <= s1_refuse ? '0 : {lut_q, lut_i};
      out_last <= s1_last;
      out_flag <= s1_refuse;
    end
  end

endmodule

### verif/tb_complex_nco_iq_generator.sv
// Self-checking testbench for the quadrature NCO: a directed table followed by random
// bursts, each checked sample by sample against an in-bench phase and sine-table predictor.
// Depends on nco_pkg and complex_nco_iq_generator.
module tb_complex_nco_iq_generator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LUT_BITS = 10;
  localparam int LUT_SIZE = 1 << LUT_BITS;
  localparam longint unsigned FULL_SCALE = 64'd32767;
  localparam longint unsigned HALF_PI_FX = 64'd1686629713;
  localparam int BURST_CAP = 64;
  localparam int QUIET_LIMIT = 2000;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 25;
  localparam int N_ROWS = 18;

  typedef struct packed {
    logic [15:0] i_val;
    logic [15:0] q_val;
    logic        last;
    logic        refused;
  } iq_t;

  typedef struct packed {
    logic        en;
    logic [31:0] step;
    logic [6:0]  count;
    logic        typed;
    iq_t         want;
  } row_t;

  localparam iq_t REFUSED = '{16'd0, 16'd0, 1'b1, 1'b1};
  localparam iq_t NONE = '0;

  localparam row_t PLAN [N_ROWS] = '{
    '{1'b0, 32'h0000_0000, 7'd5,   1'b1, REFUSED},
    '{1'b0, 32'h0000_0000, 7'd0,   1'b1, REFUSED},
    '{1'b0, 32'h0000_0000, 7'd127, 1'b1, REFUSED},
    '{1'b1, 32'h0000_0000, 7'd1,   1'b0, NONE},
    '{1'b1, 32'h0000_0000, 7'd0,   1'b0, NONE},
    '{1'b1, 32'h4000_0000, 7'd8,   1'b0, NONE},
    '{1'b1, 32'h4000_0000, 7'd64,  1'b0, NONE},
    '{1'b1, 32'h4000_0000, 7'd65,  1'b0, NONE},
    '{1'b1, 32'h0010_0000, 7'd127, 1'b0, NONE},
    '{1'b1, 32'h7FFF_FFFF, 7'd4,   1'b0, NONE},
    '{1'b1, 32'h8000_0000, 7'd4,   1'b0, NONE},
    '{1'b1, 32'hFFFF_FFFF, 7'd3,   1'b0, NONE},
    '{1'b1, 32'h0000_0001, 7'd2,   1'b0, NONE},
    '{1'b1, 32'h3FF0_0000, 7'd10,  1'b0, NONE},
    '{1'b0, 32'h3FF0_0000, 7'd64,  1'b1, REFUSED},
    '{1'b1, 32'h3FF0_0000, 7'd1,   1'b0, NONE},
    '{1'b1, 32'hC010_0000, 7'd85,  1'b0, NONE},
    '{1'b1, 32'hC010_0000, 7'd42,  1'b0, NONE}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [nco_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [nco_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_axis_tvalid = 1'b0;
  logic                           s_axis_tready;
  logic [7:0]                     s_axis_tdata = '0;
  logic                           m_axis_tvalid;
  logic                           m_axis_tready = 1'b0;
  logic [31:0]                    m_axis_tdata;
  logic                           m_axis_tlast;
  logic                           m_axis_tuser;

  logic        gen_on = 1'b0;
  logic [31:0] turn_step = '0;
  logic [31:0] phase = '0;
  int unsigned quarter_wave [0:LUT_SIZE];
  iq_t         pending [$];
  logic        steady = 1'b0;
  int          quiet = 0;
  int          mismatches = 0;
  int          requests = 0;
  int          results_seen = 0;
  int          refusals = 0;
  int          settings = 0;

  complex_nco_iq_generator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned quarter_sine(int unsigned k);
    bit [63:0] x;
    bit [63:0] t;
    bit [63:0] v;
    longint    acc;
    x   = (64'(k) * HALF_PI_FX) >> LUT_BITS;
    t   = x;
    acc = longint'(x);
    for (int n = 1; n <= 7; n++) begin
      t = (t * x) >> 30;
      t = (t * x) >> 30;
      t = t / 64'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) acc = acc - longint'(t);
      else acc = acc + longint'(t);
    end
    if (acc < 0) acc = 0;
    v = (unsigned'(acc) * FULL_SCALE + (64'd1 << 29)) >> 30;
    if (v > FULL_SCALE) v = FULL_SCALE;
    return int'(v);
  endfunction

  function automatic logic [15:0] q15_sine(logic [31:0] ph);
    logic [LUT_BITS-1:0] addr;
    logic [15:0]         mag;
    addr = ph[29:30-LUT_BITS];
    mag  = 16'(ph[30] ? quarter_wave[LUT_SIZE - int'(addr)] : quarter_wave[addr]);
    return ph[31] ? -mag : mag;
  endfunction

  function automatic void predict_burst(logic [6:0] cnt);
    int  n;
    iq_t s;
    if (!gen_on) begin
      pending.push_back(REFUSED);
      return;
    end
    n = (cnt > BURST_CAP) ? BURST_CAP : int'(cnt);
    for (int k = 0; k < n; k++) begin
      s.i_val   = q15_sine(phase + nco_pkg::QUARTER_TURN);
      s.q_val   = q15_sine(phase);
      s.last    = (k == n - 1);
      s.refused = 1'b0;
      pending.push_back(s);
      phase = phase + turn_step;
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want_v);
    $display("[%0t] mismatch on %s: got %h, want %h", $time, what, got, want_v);
    mismatches++;
  endtask

  task automatic configure(logic en, logic [31:0] stp);
    cfg_we    <= 1'b1;
    cfg_index <= nco_pkg::REG_PHASE_STEP;
    cfg_data  <= stp;
    @(posedge clk);
    cfg_index <= nco_pkg::REG_ENABLE;
    cfg_data  <= {31'd0, en};
    @(posedge clk);
    cfg_we    <= 1'b0;
    gen_on    = en;
    turn_step = stp;
    settings++;
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic request(logic [6:0] cnt, logic typed, iq_t want);
    if (!steady && $urandom_range(99) < 15) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, cnt};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    if (typed) pending.push_back(want);
    else predict_burst(cnt);
    requests++;
  endtask

  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(99) >= 15);
  end

  always @(posedge clk) begin
    iq_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected", m_axis_tdata, '0);
      end else begin
        want = pending.pop_front();
        if (m_axis_tdata[15:0] !== want.i_val)
          report_mismatch("i_sample", 32'(m_axis_tdata[15:0]), 32'(want.i_val));
        if (m_axis_tdata[31:16] !== want.q_val)
          report_mismatch("q_sample", 32'(m_axis_tdata[31:16]), 32'(want.q_val));
        if (m_axis_tlast !== want.last)
          report_mismatch("last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tuser !== want.refused)
          report_mismatch("not_running", 32'(m_axis_tuser), 32'(want.refused));
      end
      results_seen++;
      if (m_axis_tuser === 1'b1) refusals++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else if (quiet == QUIET_LIMIT) begin
      $display("[%0t] no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending.size());
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    logic [6:0]  cnt;
    logic [31:0] stp;
    logic        en;
    int          r;
    for (int k = 0; k <= LUT_SIZE; k++) quarter_wave[k] = quarter_sine(k);
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    configure(PLAN[0].en, PLAN[0].step);

    for (int row = 0; row < N_ROWS; row++) begin
      if (PLAN[row].en != gen_on || PLAN[row].step != turn_step) begin
        settle();
        configure(PLAN[row].en, PLAN[row].step);
      end
      request(PLAN[row].count, PLAN[row].typed, PLAN[row].want);
    end

    for (int p = 0; p < RAND_PHASES; p++) begin
      case ($urandom_range(3))
        0: stp = $urandom;
        1: begin
          stp = 32'($urandom_range(1 << 22, 0));
          if ($urandom_range(1) == 1) stp = -stp;
        end
        2: begin
          case ($urandom_range(3))
            0: stp = 32'h8000_0000;
            1: stp = 32'h7FFF_FFFF;
            2: stp = 32'h0000_0000;
            default: stp = 32'hFFFF_FFFF;
          endcase
        end
        default: stp = {12'($urandom_range(4095)), 20'd0};
      endcase
      en = ($urandom_range(7) != 0);
      settle();
      steady = (p == 4 || p == 5);
      configure(en, stp);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(99);
        if (r < 5) cnt = 7'd0;
        else if (r < 75) cnt = 7'($urandom_range(16, 1));
        else if (r < 90) cnt = 7'($urandom_range(64, 17));
        else cnt = 7'($urandom_range(127, 65));
        request(cnt, 1'b0, NONE);
      end
    end

    settle();
    $display("Covered %0d requests over %0d register settings, including disabled and",
             requests, settings);
    $display("saturated bursts; %0d results checked, %0d of them refusals.",
             results_seen, refusals);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
